@@ sv/mes_pkg.sv @@
// shared types and constants for the midpoint ellipse stepper
package mes_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_RADIUS_X = 2'd2;
    localparam logic [1:0] REG_RADIUS_Y = 2'd3;

    // region codes carried on the result channel
    localparam logic [1:0] REGION_AXIS = 2'd0;
    localparam logic [1:0] REGION_ONE  = 2'd1;
    localparam logic [1:0] REGION_TWO  = 2'd2;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_ONE  = 2'd1,
        PHASE_TWO  = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_RX,
        ST_SQ_RY,
        ST_RS_MUL,
        ST_RS_FIN,
        ST_P1_MUL,
        ST_P2_MUL,
        ST_CHECK,
        ST_R2_A,
        ST_R2_B,
        ST_R2_C,
        ST_R2_D,
        ST_R2_E,
        ST_STEP1,
        ST_STEP2
    } state_t;

    // multiplier operand selection
    typedef enum logic [3:0] {
        MUL_RX_SQ,
        MUL_RY_SQ,
        MUL_RX2_RY,
        MUL_RX2_Y,
        MUL_RY2_X,
        MUL_T_SQ,
        MUL_RY2_PROD,
        MUL_YM1_SQ,
        MUL_RX2_PROD,
        MUL_RX2_RY2
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD4
    } acc_op_t;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_RESTART,
        UPD_R2START,
        UPD_STEP1,
        UPD_STEP2
    } upd_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     ld_rx2;
        logic     ld_ry2;
        logic     ld_p1;
        logic     ld_p2;
        acc_op_t  acc_op;
        upd_t     upd;
        logic     commit;
    } mes_cmd_t;

    typedef struct packed {
        logic cmp_r1;
        logic radius_zero;
        logic last;
    } mes_status_t;

endpackage

@@ sv/mes_datapath.sv @@
// datapath: configuration registers, shared multiplier, decision update, result register
module mes_datapath import mes_pkg::*; #(
    parameter int COORD_BITS  = 10,
    parameter int RADIUS_BITS = 9
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)-1:0] cfg_data,
    input  mes_cmd_t                cmd,
    output mes_status_t             status,
    output logic [COORD_BITS+1:0]   right_x,
    output logic [COORD_BITS+1:0]   left_x,
    output logic [COORD_BITS+1:0]   lower_y,
    output logic [COORD_BITS+1:0]   upper_y,
    output logic [1:0]              region,
    output logic                    last
);

    localparam int RB  = RADIUS_BITS;
    localparam int CB  = COORD_BITS;
    localparam int OFW = RB + 1;
    localparam int MA  = 2 * RB;
    localparam int MB  = 2 * RB + 4;
    localparam int PW  = MA + MB;
    localparam int PQ  = 3 * RB + 1;
    localparam int DW  = 4 * RB + 8;
    localparam int OW  = CB + 2;
    localparam int SW  = (OW > RB + 2) ? OW : RB + 2;

    logic [CB-1:0]  center_x_reg, center_y_reg;
    logic [RB-1:0]  radius_x_reg, radius_y_reg;
    logic [OFW-1:0] x_reg, y_reg;
    logic [DW-1:0]  d_reg, acc_reg;
    logic [MA-1:0]  rx2_reg, ry2_reg;
    logic [PQ-1:0]  p1_reg, p2_reg;
    logic [PW-1:0]  prod_reg;
    logic [OW-1:0]  right_x_reg, left_x_reg, lower_y_reg, upper_y_reg;
    logic [1:0]     region_reg;
    logic           last_reg;

    logic [MA-1:0]  mul_a;
    logic [MB-1:0]  mul_b;
    logic [RB+1:0]  t_val;
    logic [OFW-1:0] y_m1, x_p1;
    logic [DW-1:0]  prod_ext, rx2_ext, ry2_ext, p1_ext, p2_ext;
    logic [DW-1:0]  inc_x_term, dec_y_term, d_restart;
    logic [OFW-1:0] x_n, y_n;
    logic [DW-1:0]  d_n;
    logic [1:0]     region_n;
    logic           last_n;
    logic           emit;
    logic [SW-1:0]  rx_sum, lx_sum, ly_sum, uy_sum;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_x_reg <= RB'(1);
            radius_y_reg <= RB'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data[CB-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_data[CB-1:0];
                REG_RADIUS_X: radius_x_reg <= cfg_data[RB-1:0];
                REG_RADIUS_Y: radius_y_reg <= cfg_data[RB-1:0];
            endcase
        end
    end

    assign t_val = {x_reg, 1'b1};
    assign y_m1  = y_reg - OFW'(1);
    assign x_p1  = x_reg + OFW'(1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_RX_SQ: begin
                mul_a = MA'(radius_x_reg);
                mul_b = MB'(radius_x_reg);
            end
            MUL_RY_SQ: begin
                mul_a = MA'(radius_y_reg);
                mul_b = MB'(radius_y_reg);
            end
            MUL_RX2_RY: begin
                mul_a = rx2_reg;
                mul_b = MB'(radius_y_reg);
            end
            MUL_RX2_Y: begin
                mul_a = rx2_reg;
                mul_b = MB'(y_reg);
            end
            MUL_RY2_X: begin
                mul_a = ry2_reg;
                mul_b = MB'(x_reg);
            end
            MUL_T_SQ: begin
                mul_a = MA'(t_val);
                mul_b = MB'(t_val);
            end
            MUL_RY2_PROD: begin
                mul_a = ry2_reg;
                mul_b = prod_reg[MB-1:0];
            end
            MUL_YM1_SQ: begin
                mul_a = MA'(y_m1);
                mul_b = MB'(y_m1);
            end
            MUL_RX2_PROD: begin
                mul_a = rx2_reg;
                mul_b = prod_reg[MB-1:0];
            end
            MUL_RX2_RY2: begin
                mul_a = rx2_reg;
                mul_b = MB'(ry2_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_ext = DW'(prod_reg);
    assign rx2_ext  = DW'(rx2_reg);
    assign ry2_ext  = DW'(ry2_reg);
    assign p1_ext   = DW'(p1_reg);
    assign p2_ext   = DW'(p2_reg);

    // ry2*(x+1) and rx2*(y-1) come from the products taken at the old offsets
    assign inc_x_term = (p2_ext + ry2_ext) << 3;
    assign dec_y_term = (p1_ext - rx2_ext) << 3;
    assign d_restart  = (ry2_ext << 2) - (prod_ext << 2) + rx2_ext;

    always_comb begin
        x_n      = x_reg;
        y_n      = y_reg;
        d_n      = d_reg;
        region_n = REGION_AXIS;
        emit     = 1'b0;
        unique case (cmd.upd)
            UPD_RESTART: begin
                x_n  = '0;
                y_n  = OFW'(radius_y_reg);
                d_n  = d_restart;
                emit = 1'b1;
            end
            UPD_R2START: begin
                d_n = acc_reg - (prod_ext << 2);
            end
            UPD_STEP1: begin
                region_n = REGION_ONE;
                emit     = 1'b1;
                x_n      = x_p1;
                if (d_reg[DW-1]) begin
                    d_n = d_reg + inc_x_term + (ry2_ext << 2);
                end else begin
                    y_n = y_m1;
                    d_n = d_reg + inc_x_term + (ry2_ext << 2) - dec_y_term;
                end
            end
            UPD_STEP2: begin
                region_n = REGION_TWO;
                emit     = 1'b1;
                y_n      = y_m1;
                if (d_reg[DW-1]) begin
                    x_n = x_p1;
                    d_n = d_reg + inc_x_term + (rx2_ext << 2) - dec_y_term;
                end else begin
                    d_n = d_reg + (rx2_ext << 2) - dec_y_term;
                end
            end
            default: begin
                x_n = x_reg;
            end
        endcase
    end

    assign status.radius_zero = (radius_x_reg == '0) || (radius_y_reg == '0);
    assign status.cmp_r1      = p1_reg >= prod_reg[PQ-1:0];
    assign last_n = (cmd.upd == UPD_RESTART) ? status.radius_zero : (y_n == '0);
    assign status.last = last_n;

    assign rx_sum = SW'(center_x_reg) + SW'(x_n);
    assign lx_sum = SW'(center_x_reg) - SW'(x_n);
    assign ly_sum = SW'(center_y_reg) + SW'(y_n);
    assign uy_sum = SW'(center_y_reg) - SW'(y_n);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.ld_rx2) begin
            rx2_reg <= prod_reg[MA-1:0];
        end
        if (cmd.ld_ry2) begin
            ry2_reg <= prod_reg[MA-1:0];
        end
        if (cmd.ld_p1) begin
            p1_reg <= prod_reg[PQ-1:0];
        end
        if (cmd.ld_p2) begin
            p2_reg <= prod_reg[PQ-1:0];
        end
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= prod_ext;
            ACC_ADD4: acc_reg <= acc_reg + (prod_ext << 2);
            default:  acc_reg <= acc_reg;
        endcase
        if (cmd.commit) begin
            x_reg <= x_n;
            y_reg <= y_n;
            d_reg <= d_n;
            if (emit) begin
                right_x_reg <= rx_sum[OW-1:0];
                left_x_reg  <= lx_sum[OW-1:0];
                lower_y_reg <= ly_sum[OW-1:0];
                upper_y_reg <= uy_sum[OW-1:0];
                region_reg  <= region_n;
                last_reg    <= last_n;
            end
        end
    end

    assign right_x = right_x_reg;
    assign left_x  = left_x_reg;
    assign lower_y = lower_y_reg;
    assign upper_y = upper_y_reg;
    assign region  = region_reg;
    assign last    = last_reg;

endmodule

@@ sv/mes_control.sv @@
// controller: step sequencer, phase tracking and handshakes
module mes_control import mes_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_restart,
    output logic        m_valid,
    input  logic        m_ready,
    output mes_cmd_t    cmd,
    input  mes_status_t status
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   restart_reg, restart_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PHASE_IDLE;
            restart_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            restart_reg   <= restart_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        restart_next   = restart_reg;
        out_valid_next = out_valid_reg && !m_ready;
        s_ready        = 1'b0;
        cmd.mul_sel    = MUL_RX_SQ;
        cmd.ld_rx2     = 1'b0;
        cmd.ld_ry2     = 1'b0;
        cmd.ld_p1      = 1'b0;
        cmd.ld_p2      = 1'b0;
        cmd.acc_op     = ACC_HOLD;
        cmd.upd        = UPD_NONE;
        cmd.commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    restart_next = s_restart;
                    // an advance with no ellipse running is dropped here
                    if (s_restart || phase_reg == PHASE_ONE || phase_reg == PHASE_TWO) begin
                        state_next = ST_SQ_RX;
                    end
                end
            end
            ST_SQ_RX: begin
                cmd.mul_sel = MUL_RX_SQ;
                state_next  = ST_SQ_RY;
            end
            ST_SQ_RY: begin
                cmd.mul_sel = MUL_RY_SQ;
                cmd.ld_rx2  = 1'b1;
                state_next  = restart_reg ? ST_RS_MUL : ST_P1_MUL;
            end
            ST_RS_MUL: begin
                cmd.mul_sel = MUL_RX2_RY;
                cmd.ld_ry2  = 1'b1;
                state_next  = ST_RS_FIN;
            end
            ST_RS_FIN: begin
                // keep rx2*ry in the product register while the output is stalled
                cmd.mul_sel = MUL_RX2_RY;
                cmd.upd     = UPD_RESTART;
                cmd.commit  = out_free;
                if (out_free) begin
                    phase_next     = status.radius_zero ? PHASE_IDLE : PHASE_ONE;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_P1_MUL: begin
                cmd.mul_sel = MUL_RX2_Y;
                cmd.ld_ry2  = 1'b1;
                state_next  = ST_P2_MUL;
            end
            ST_P2_MUL: begin
                cmd.mul_sel = MUL_RY2_X;
                cmd.ld_p1   = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK: begin
                // (2x+1)^2 is started in case region one has just ended
                cmd.mul_sel = MUL_T_SQ;
                cmd.ld_p2   = 1'b1;
                if (phase_reg == PHASE_ONE && status.cmp_r1) begin
                    state_next = ST_STEP1;
                end else if (phase_reg == PHASE_ONE) begin
                    state_next = ST_R2_A;
                end else begin
                    state_next = ST_STEP2;
                end
            end
            ST_R2_A: begin
                cmd.mul_sel = MUL_RY2_PROD;
                state_next  = ST_R2_B;
            end
            ST_R2_B: begin
                cmd.mul_sel = MUL_YM1_SQ;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_R2_C;
            end
            ST_R2_C: begin
                cmd.mul_sel = MUL_RX2_PROD;
                state_next  = ST_R2_D;
            end
            ST_R2_D: begin
                cmd.mul_sel = MUL_RX2_RY2;
                cmd.acc_op  = ACC_ADD4;
                state_next  = ST_R2_E;
            end
            ST_R2_E: begin
                cmd.upd    = UPD_R2START;
                cmd.commit = 1'b1;
                state_next = ST_STEP2;
            end
            ST_STEP1: begin
                cmd.upd    = UPD_STEP1;
                cmd.commit = out_free;
                if (out_free) begin
                    phase_next     = status.last ? PHASE_IDLE : PHASE_ONE;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_STEP2: begin
                cmd.upd    = UPD_STEP2;
                cmd.commit = out_free;
                if (out_free) begin
                    phase_next     = status.last ? PHASE_IDLE : PHASE_TWO;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

@@ sv/midpoint_ellipse_stepper.sv @@
// Midpoint ellipse stepper, top level.
// Usage: set center and radii on the cfg channel (index 0 center_x, 1 center_y,
// 2 radius_x, 3 radius_y), then send a transaction with restart = 1 to start a
// new ellipse and restart = 0 transactions to walk it one step at a time.
// Each restart gives the two axis points (region 0); each advance gives the four
// mirror points of one step in region 1 or region 2. The step that reaches
// y = 0 has tlast set and ends the run; further advances give no result.
// From input acceptance to m_axis_tvalid, a restart runs ST_SQ_RX, ST_SQ_RY,
// ST_RS_MUL and ST_RS_FIN; an advance runs ST_SQ_RX, ST_SQ_RY, ST_P1_MUL,
// ST_P2_MUL, ST_CHECK and ST_STEP1 or ST_STEP2, and the advance that crosses
// into region 2 adds ST_R2_A to ST_R2_E, where the region-2 start value needs
// four more products and a combining step. One item is in work at a time; the
// next goes in the cycle after its result is written; idle advances are dropped.
// The steps are set by the single shared multiplier, which takes one product
// per cycle. The result sits in an output register, so a stalled receiver does
// not block the next input until that result must be replaced.
// Reset (aresetn low, synchronous) clears the run, drops any pending result and
// returns the registers to center 0, radii 1. cfg_ready is always high.
module midpoint_ellipse_stepper import mes_pkg::*; #(
    parameter int COORD_BITS  = 10,
    parameter int RADIUS_BITS = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)-1:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // right_x, left_x, lower_y, upper_y, zero fill
    output logic [((4*(COORD_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // region
    output logic        m_axis_tlast
);

    localparam int OW  = COORD_BITS + 2;
    localparam int TDW = ((4 * OW + 7) / 8) * 8;

    mes_cmd_t      cmd;
    mes_status_t   status;
    logic [OW-1:0] right_x, left_x, lower_y, upper_y;

    assign cfg_ready = 1'b1;

    mes_control u_control (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_restart (s_axis_tdata[0]),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    mes_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .right_x   (right_x),
        .left_x    (left_x),
        .lower_y   (lower_y),
        .upper_y   (upper_y),
        .region    (m_axis_tuser),
        .last      (m_axis_tlast)
    );

    assign m_axis_tdata = TDW'({upper_y, lower_y, left_x, right_x});

endmodule

@@ sv/mes_checker.sv @@
// port-level checker for the midpoint ellipse stepper, bound to the top level
module mes_checker import mes_pkg::*; #(
    parameter int COORD_BITS  = 10
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [((4*(COORD_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    localparam int OW = COORD_BITS + 2;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // a restart always occupies the block, so the input is not ready right after it
    a_restart_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[0] |=> !s_axis_tready)
        else $error("input accepted right after a restart");

    // axis points have x offset zero
    a_axis_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == REGION_AXIS |->
            m_axis_tdata[OW-1:0] == m_axis_tdata[2*OW-1:OW])
        else $error("axis points not on the vertical axis");

    // the final step of a run lands on y offset zero
    a_last_y: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast && m_axis_tuser != REGION_AXIS |->
            m_axis_tdata[3*OW-1:2*OW] == m_axis_tdata[4*OW-1:3*OW])
        else $error("last step not on the horizontal axis");

endmodule

bind midpoint_ellipse_stepper mes_checker #(
    .COORD_BITS  (COORD_BITS)
) u_mes_checker (.*);
